// ===== rtl/bmp565_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp565_pkg: shared types and constants
// Register map, field widths and the per-beat state and result records of
// the 24-bit bitmap to RGB565 pixel converter.
// ----------------------------------------------------------------------------
package bmp565_pkg;

	// Parameter defaults
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Width of the size arithmetic: holds 4096 and any 11-bit register value
	localparam int CALC_W = 13;

	// Register field widths
	localparam int SIZE_W   = 11;
	localparam int CODE_W   = 8;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 11;

	// Output field widths
	localparam int PIX_W = 16;
	localparam int POS_W = 10;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_DEPTH      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSION_MODE = 8'd3;

	// Register reset values
	localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH      = 11'd320;
	localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT     = 11'd240;
	localparam logic [CODE_W-1:0] RST_COLOR_DEPTH      = 8'd24;
	localparam logic [CODE_W-1:0] RST_COMPRESSION_MODE = 8'd0;

	// Only supported format
	localparam logic [CODE_W-1:0] BPP_SUPPORTED  = 8'd24;
	localparam logic [CODE_W-1:0] COMP_SUPPORTED = 8'd0;

	// Status codes
	localparam logic STATUS_OK          = 1'b0;
	localparam logic STATUS_UNSUPPORTED = 1'b1;

	// Which byte of the pixel comes next
	typedef enum logic [1:0] {
		PH_BLUE  = 2'd0,
		PH_GREEN = 2'd1,
		PH_RED   = 2'd2
	} phase_t;

	// Per-byte state that does not depend on the size parameters
	typedef struct packed {
		phase_t       phase;
		logic [1:0]   pad;
		logic [7:0]   blue;
		logic [7:0]   green;
	} byte_state_t;

	// One result beat
	typedef struct packed {
		logic             status;
		logic [PIX_W-1:0] pixel;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             row_last;
		logic             image_last;
	} result_t;

endpackage

// ===== rtl/bmp565_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp565_step: per-byte next-state and result logic
// Decodes one pixel-data byte at the current position, drops row padding,
// packs RGB565 on the red byte and flags row and image ends or bad formats.
// ----------------------------------------------------------------------------
module bmp565_step #(
	parameter int MAX_WIDTH  = bmp565_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmp565_pkg::MAX_HEIGHT_DEF,
	parameter int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
	parameter int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  bmp565_pkg::byte_state_t          cur,
	input  logic [CW-1:0]                    col_cnt,
	input  logic [RW-1:0]                    row_cnt,
	input  logic [bmp565_pkg::SIZE_W-1:0]    image_width,
	input  logic [bmp565_pkg::SIZE_W-1:0]    image_height,
	input  logic [bmp565_pkg::CODE_W-1:0]    color_depth,
	input  logic [bmp565_pkg::CODE_W-1:0]    compression_mode,
	input  logic [7:0]                       data_byte,
	input  logic                             image_start,
	output bmp565_pkg::byte_state_t          nxt,
	output logic [CW-1:0]                    col_nxt,
	output logic [RW-1:0]                    row_nxt,
	output logic                             emit,
	output bmp565_pkg::result_t              res
);
	import bmp565_pkg::*;

	byte_state_t       eff;
	logic [CW-1:0]     col_eff;
	logic [RW-1:0]     row_eff;
	logic              fmt_ok;
	logic [CALC_W-1:0] w_ext, h_ext, wm1, hm1, wp1, col_ext, row_ext, row_pos;
	logic              rlast, row_done, ilast;

	// Start of image clears position before the byte is used
	always_comb begin
		eff     = cur;
		col_eff = col_cnt;
		row_eff = row_cnt;
		if (image_start) begin
			eff.phase = PH_BLUE;
			eff.pad   = 2'd0;
			col_eff   = '0;
			row_eff   = '0;
		end
	end

	assign fmt_ok = (color_depth == BPP_SUPPORTED) && (compression_mode == COMP_SUPPORTED);

	// Clamp size to 1..MAX, kept as size minus one
	assign w_ext = CALC_W'(image_width);
	assign h_ext = CALC_W'(image_height);
	assign wm1 = (w_ext == '0) ? '0 :
		(w_ext > CALC_W'(MAX_WIDTH)) ? CALC_W'(MAX_WIDTH - 1) : w_ext - 1'b1;
	assign hm1 = (h_ext == '0) ? '0 :
		(h_ext > CALC_W'(MAX_HEIGHT)) ? CALC_W'(MAX_HEIGHT - 1) : h_ext - 1'b1;
	assign wp1 = wm1 + 1'b1;

	assign col_ext  = CALC_W'(col_eff);
	assign row_ext  = CALC_W'(row_eff);
	assign rlast    = (col_ext >= wm1);
	assign row_done = (row_ext >= hm1);
	assign ilast    = rlast && row_done;
	assign row_pos  = row_done ? '0 : (hm1 - row_ext);

	always_comb begin
		nxt     = eff;
		col_nxt = col_eff;
		row_nxt = row_eff;
		emit    = 1'b0;
		res     = '0;
		if (!fmt_ok) begin
			emit       = 1'b1;
			res.status = STATUS_UNSUPPORTED;
		end else if (eff.pad != 2'd0) begin
			nxt.pad = eff.pad - 2'd1;
		end else begin
			case (eff.phase)
				PH_BLUE: begin
					nxt.blue  = data_byte;
					nxt.phase = PH_GREEN;
				end
				PH_GREEN: begin
					nxt.green = data_byte;
					nxt.phase = PH_RED;
				end
				default: begin
					emit           = 1'b1;
					res.status     = STATUS_OK;
					res.pixel      = {data_byte[7:3], eff.green[7:2], eff.blue[7:3]};
					res.column     = col_ext[POS_W-1:0];
					res.row        = row_pos[POS_W-1:0];
					res.row_last   = rlast;
					res.image_last = ilast;
					nxt.phase      = PH_BLUE;
					if (rlast) begin
						col_nxt = '0;
						nxt.pad = wp1[1:0];
						row_nxt = ilast ? '0 : row_eff + 1'b1;
					end else begin
						col_nxt = col_eff + 1'b1;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/bmp24_pixel_stream_to_rgb565_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_to_rgb565_core: bitmap pixel bytes to RGB565 pixels
// The pixel beat of an accepted red byte is registered before it is shown.
// Throughput: one byte per cycle, set by the single result register; a byte
// is taken even while a pixel waits, unless that pixel is stalled.
// Reset: position and phase clear, registers take 320 x 240, 24 bpp, no
// compression; the result register comes up empty.
// ----------------------------------------------------------------------------
module bmp24_pixel_stream_to_rgb565_core #(
	parameter int MAX_WIDTH  = bmp565_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmp565_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bmp565_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmp565_pkg::CFG_DAT_W-1:0]   cfg_data,
	// Byte input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               image_start,
	// Pixel output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               status,
	output logic [bmp565_pkg::PIX_W-1:0]       pixel_rgb565,
	output logic [bmp565_pkg::POS_W-1:0]       column,
	output logic [bmp565_pkg::POS_W-1:0]       row,
	output logic                               row_last,
	output logic                               image_last
);
	import bmp565_pkg::*;

	localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// Configuration registers
	logic [SIZE_W-1:0] image_width_q, image_height_q;
	logic [CODE_W-1:0] color_depth_q, compression_mode_q;

	// Position and held color state
	byte_state_t   st_q, st_nxt;
	logic [CW-1:0] col_q, col_nxt;
	logic [RW-1:0] row_q, row_nxt;

	// Result register
	logic    out_valid_s1;
	result_t res_s1, res_nxt;
	logic    emit;
	logic    accept;

	// Registers are always writable; host must write only while idle, unenforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q      <= RST_IMAGE_WIDTH;
			image_height_q     <= RST_IMAGE_HEIGHT;
			color_depth_q      <= RST_COLOR_DEPTH;
			compression_mode_q <= RST_COMPRESSION_MODE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:      image_width_q      <= cfg_data;
				CFG_IMAGE_HEIGHT:     image_height_q     <= cfg_data;
				CFG_COLOR_DEPTH:      color_depth_q      <= cfg_data[CODE_W-1:0];
				CFG_COMPRESSION_MODE: compression_mode_q <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the input only while a finished pixel is stalled downstream
	assign in_stall = out_valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	bmp565_step #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW),
		.RW         (RW)
	) u_step (
		.cur              (st_q),
		.col_cnt          (col_q),
		.row_cnt          (row_q),
		.image_width      (image_width_q),
		.image_height     (image_height_q),
		.color_depth      (color_depth_q),
		.compression_mode (compression_mode_q),
		.data_byte        (data_byte),
		.image_start      (image_start),
		.nxt              (st_nxt),
		.col_nxt          (col_nxt),
		.row_nxt          (row_nxt),
		.emit             (emit),
		.res              (res_nxt)
	);

	// Advance position state on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_BLUE;
			st_q.pad   <= 2'd0;
			st_q.blue  <= 8'd0;
			st_q.green <= 8'd0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (accept) begin
			st_q  <= st_nxt;
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// Result stage: load on a pixel-producing beat, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (accept) begin
			out_valid_s1 <= emit;
		end else if (!out_stall) begin
			out_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_s1 <= res_nxt;
		end
	end

	assign out_valid    = out_valid_s1;
	assign status       = res_s1.status;
	assign pixel_rgb565 = res_s1.pixel;
	assign column       = res_s1.column;
	assign row          = res_s1.row;
	assign row_last     = res_s1.row_last;
	assign image_last   = res_s1.image_last;

endmodule
